// ----- src/wall_follow_steering_decider_defines.svh -----
// Assertion macros for the wall-follow steering decider.
`ifndef WALL_FOLLOW_STEERING_DECIDER_DEFINES_SVH
`define WALL_FOLLOW_STEERING_DECIDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WFSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WFSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WFSD_ASSERT(lbl, clk, rst, prop, msg)
`define WFSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- src/wfsd_pkg.sv -----
// Shared types and constants of the wall-follow steering decider.
`default_nettype none

package wfsd_pkg;

   localparam int WINDOW_LEN_DEF = 8;

   localparam int BYTE_W = 8;
   localparam int HOLD_W = 7;
   localparam int CMD_W  = 3;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE         = 3'd0,
      CMD_RIGHT_STRONG = 3'd1,
      CMD_RIGHT_MILD   = 3'd2,
      CMD_LEFT_STRONG  = 3'd3,
      CMD_LEFT_MILD    = 3'd4
   } cmd_type;

   // register index, taken from paddr[2]
   typedef enum logic {
      CSR_CORR_EN = 1'b0,
      CSR_TEMP_EN = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic corr_en;
      logic temp_en;
   } cfg_type;

   typedef struct packed {
      logic                window_done;
      logic [BYTE_W-1:0]   avg_ir;
      logic [BYTE_W-1:0]   avg_ahead;
      logic [BYTE_W-1:0]   avg_front;
      logic [BYTE_W-1:0]   avg_back;
      logic                finish_flag;
      cmd_type             trend_command;
      cmd_type             boundary_command;
      logic                blind_spot_command;
      logic [HOLD_W-1:0]   left_hold;
      logic [HOLD_W-1:0]   right_hold;
   } res_type;

   localparam logic [BYTE_W-1:0] LEN_MIN      = 8'd3;
   localparam int                NEAR_LIMIT   = 13;
   localparam int                RING_CEIL    = 150;
   localparam int                FRONT_VETO   = 175;
   localparam int                IR_VETO      = 7;
   localparam int                OFF_STRONG   = -25;
   localparam int                OFF_MILD     = -15;
   localparam int                IR_STRONG    = 105;
   localparam int                IR_MILD      = 90;
   localparam int                TREND_STRONG = 7;
   localparam int                TREND_MILD   = 3;
   localparam logic [BYTE_W-1:0] REF_DISABLED = 8'hFF;
   localparam logic [BYTE_W:0]   BLIND_MARGIN = 9'd10;
   localparam logic [HOLD_W-1:0] HOLD_LONG    = 7'd70;
   localparam logic [HOLD_W-1:0] HOLD_MID     = 7'd50;
   localparam logic [HOLD_W-1:0] HOLD_SHORT   = 7'd30;

endpackage

`default_nettype wire

// ----- src/wfsd_req_if.sv -----
// Input channel of the steering decider: one sensor-message item.
`default_nettype none

interface wfsd_req_if;
   import wfsd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] msg_length;
   logic [BYTE_W-1:0] ir_sample;
   logic [BYTE_W-1:0] ahead_sample;
   logic [BYTE_W-1:0] front_sample;
   logic [BYTE_W-1:0] back_sample;
   logic              finish_seen;

   modport source (
      output valid, msg_length, ir_sample, ahead_sample, front_sample, back_sample,
             finish_seen,
      input  ready
   );

   modport sink (
      input  valid, msg_length, ir_sample, ahead_sample, front_sample, back_sample,
             finish_seen,
      output ready
   );

endinterface

`default_nettype wire

// ----- src/wfsd_rsp_if.sv -----
// Result channel of the steering decider: one result item per tick.
`default_nettype none

interface wfsd_rsp_if;
   import wfsd_pkg::*;

   logic              valid;
   logic              ready;
   logic              window_done;
   logic [BYTE_W-1:0] avg_ir;
   logic [BYTE_W-1:0] avg_ahead;
   logic [BYTE_W-1:0] avg_front;
   logic [BYTE_W-1:0] avg_back;
   logic              finish_flag;
   logic [CMD_W-1:0]  trend_command;
   logic [CMD_W-1:0]  boundary_command;
   logic              blind_spot_command;
   logic [HOLD_W-1:0] left_hold;
   logic [HOLD_W-1:0] right_hold;

   modport source (
      output valid, window_done, avg_ir, avg_ahead, avg_front, avg_back, finish_flag,
             trend_command, boundary_command, blind_spot_command, left_hold, right_hold,
      input  ready
   );

   modport sink (
      input  valid, window_done, avg_ir, avg_ahead, avg_front, avg_back, finish_flag,
             trend_command, boundary_command, blind_spot_command, left_hold, right_hold,
      output ready
   );

endinterface

`default_nettype wire

// ----- src/wfsd_csr.sv -----
// APB-style register block holding the two correction enables.
`default_nettype none

module wfsd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wfsd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [wfsd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [wfsd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready,
   output wfsd_pkg::cfg_type           cfg
);
   import wfsd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_fire;

   assign csr_pready = 1'b1;
   assign idx        = csr_idx_type'(csr_paddr[2]);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (idx)
            CSR_CORR_EN: cfg_in.corr_en = csr_pwdata[0];
            CSR_TEMP_EN: cfg_in.temp_en = csr_pwdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         CSR_CORR_EN: csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.corr_en};
         CSR_TEMP_EN: csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.temp_en};
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/wall_follow_steering_decider.sv -----
// Top level of the wall-follow steering decider: sample windows, averaging, steering rules.
// An item that closes no window goes straight to the push state, where its result is registered
// once the output register is free. An item that closes a window first walks the sample memory,
//   divides the four channel sums on the shared reciprocal multiplier, and may walk the ring.
// Throughput: one item at a time; a new item is taken once the last result is registered.
// Reset: synchronous, clears control state; memories are not swept (written before read).
`default_nettype none
`include "wall_follow_steering_decider_defines.svh"

module wall_follow_steering_decider #(
   parameter int WINDOW_LEN = wfsd_pkg::WINDOW_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   wfsd_req_if.sink                    req_bus,
   wfsd_rsp_if.source                  rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wfsd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [wfsd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [wfsd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import wfsd_pkg::*;

   localparam int IDX_W       = $clog2(WINDOW_LEN);
   localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W       = BYTE_W + $clog2(WINDOW_LEN);
   localparam int DIFF_W      = $clog2(12 * WINDOW_LEN) + 1;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
   localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW_LEN);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SUM   = 9'b000000010,
      ST_DIV   = 9'b000000100,
      ST_CAL   = 9'b000001000,
      ST_RING  = 9'b000010000,
      ST_WALK  = 9'b000100000,
      ST_TREND = 9'b001000000,
      ST_BOUND = 9'b010000000,
      ST_PUSH  = 9'b100000000
   } state_type;

   cfg_type cfg;
   logic    cfg_en;

   wfsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign cfg_en = cfg.corr_en && cfg.temp_en;

   // memories: four sample bytes per entry, and the ring of front averages
   logic [4*BYTE_W-1:0] window_mem [WINDOW_LEN];
   logic [BYTE_W-1:0]   ring_mem   [WINDOW_LEN];
   logic [4*BYTE_W-1:0] win_rd_ff;
   logic [BYTE_W-1:0]   ring_rd_ff;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [IDX_W-1:0]    ring_slot_ff, ring_slot_in;
   logic [HOLD_W-1:0]   left_ff, left_in;
   logic [HOLD_W-1:0]   right_ff, right_in;
   logic [BYTE_W-1:0]   ref_ff, ref_in;
   logic [BYTE_W-1:0]   wall_ff, wall_in;
   logic                awaiting_ff, awaiting_in;
   logic                fin_pend_ff, fin_pend_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SUM_W-1:0]    sum_ir_ff, sum_ir_in;
   logic [SUM_W-1:0]    sum_ahead_ff, sum_ahead_in;
   logic [SUM_W-1:0]    sum_front_ff, sum_front_in;
   logic [SUM_W-1:0]    sum_back_ff, sum_back_in;
   logic [BYTE_W-1:0]   avg_ir_ff, avg_ir_in;
   logic [BYTE_W-1:0]   avg_ahead_ff, avg_ahead_in;
   logic [BYTE_W-1:0]   avg_front_ff, avg_front_in;
   logic [BYTE_W-1:0]   avg_back_ff, avg_back_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [BYTE_W-1:0]   prev_ff, prev_in;
   res_type             res_ff, res_in;
   res_type             out_ff, out_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_acc;
   logic                msg_ok;
   logic                push_fire;
   logic [IDX_W-1:0]    rd_idx;
   logic [SUM_W-1:0]    sum_sel;
   logic [PROD_W-1:0]   prod;
   logic [BYTE_W-1:0]   quot;
   logic signed [BYTE_W:0]   step;
   logic                term_ok;
   logic signed [BYTE_W+1:0] off;
   logic                veto;
   cmd_type             trend_cmd, bound_cmd;
   logic [HOLD_W-1:0]   trend_l, trend_r, bound_l, bound_r, final_l, final_r;
   logic                blind_hit;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign msg_ok        = (req_bus.msg_length > LEN_MIN) && (req_bus.front_sample != '0)
                          && (req_bus.back_sample != '0);
   assign push_fire     = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_bus.ready);
   assign rd_idx        = cnt_ff[IDX_W-1:0];

   // sample writes happen at acceptance, before the sum walk starts: no overlap
   always_ff @(posedge clock) begin
      if (req_acc && msg_ok) begin
         window_mem[slot_ff] <= {req_bus.ir_sample, req_bus.ahead_sample,
                                 req_bus.front_sample, req_bus.back_sample};
      end
      win_rd_ff <= window_mem[rd_idx];
   end

   // ring write in ST_RING always precedes the ring walk
   always_ff @(posedge clock) begin
      if (state_ff == ST_RING) begin
         ring_mem[ring_slot_ff] <= avg_front_ff;
      end
      ring_rd_ff <= ring_mem[rd_idx];
   end

   // shared reciprocal multiply, one channel per cycle
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sum_sel = sum_ir_ff;
         2'd1:    sum_sel = sum_ahead_ff;
         2'd2:    sum_sel = sum_front_ff;
         default: sum_sel = sum_back_ff;
      endcase
      prod = PROD_W'(sum_sel) * PROD_W'(RECIP);
      quot = prod[RECIP_SHIFT+BYTE_W-1:RECIP_SHIFT];
   end

   // adjacent difference of the ring walk
   always_comb begin
      step    = $signed({1'b0, ring_rd_ff}) - $signed({1'b0, prev_ff});
      term_ok = (step > -NEAR_LIMIT) && (step < NEAR_LIMIT)
                && (prev_ff < RING_CEIL) && (ring_rd_ff < RING_CEIL);
   end

   // steering rules; boundary sees holds left by the trend rule, blind spot those of boundary
   always_comb begin
      veto = (avg_front_ff > FRONT_VETO) || (avg_ir_ff < IR_VETO);
      off  = $signed({2'b00, wall_ff}) - $signed({2'b00, avg_front_ff});

      trend_cmd = CMD_NONE;
      trend_l   = left_ff;
      trend_r   = right_ff;
      if (!veto) begin
         if (diff_ff > TREND_STRONG) begin
            trend_cmd = CMD_RIGHT_STRONG; trend_l = HOLD_LONG; trend_r = HOLD_MID;
         end else if (diff_ff > TREND_MILD) begin
            trend_cmd = CMD_RIGHT_MILD; trend_l = HOLD_SHORT; trend_r = HOLD_MID;
         end else if (diff_ff < -TREND_STRONG) begin
            trend_cmd = CMD_LEFT_STRONG; trend_l = HOLD_MID; trend_r = HOLD_LONG;
         end else if (diff_ff < -TREND_MILD) begin
            trend_cmd = CMD_LEFT_MILD; trend_l = HOLD_MID; trend_r = HOLD_SHORT;
         end
      end

      bound_cmd = CMD_NONE;
      bound_l   = left_ff;
      bound_r   = right_ff;
      if (!veto) begin
         if (off < OFF_STRONG && right_ff == '0) begin
            bound_cmd = CMD_RIGHT_STRONG; bound_l = HOLD_MID; bound_r = HOLD_LONG;
         end else if (off < OFF_MILD && right_ff == '0) begin
            bound_cmd = CMD_RIGHT_MILD; bound_l = HOLD_SHORT; bound_r = HOLD_MID;
         end else if (avg_ir_ff > IR_STRONG && left_ff == '0) begin
            bound_cmd = CMD_LEFT_STRONG; bound_l = HOLD_LONG; bound_r = HOLD_MID;
         end else if (avg_ir_ff > IR_MILD && left_ff == '0) begin
            bound_cmd = CMD_LEFT_MILD; bound_l = HOLD_MID; bound_r = HOLD_SHORT;
         end
      end

      // front - 10 < ref, rewritten as front < ref + 10
      blind_hit = (ref_ff != '0) && (ref_ff != REF_DISABLED) && (avg_front_ff < RING_CEIL)
                  && ({1'b0, avg_front_ff} < ({1'b0, ref_ff} + BLIND_MARGIN))
                  && (bound_l == '0);
      final_l = blind_hit ? HOLD_LONG : bound_l;
      final_r = blind_hit ? HOLD_MID  : bound_r;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      ring_slot_in = ring_slot_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      ref_in       = ref_ff;
      wall_in      = wall_ff;
      awaiting_in  = awaiting_ff;
      fin_pend_in  = fin_pend_ff;
      rd_vld_in    = 1'b0;
      sum_ir_in    = sum_ir_ff;
      sum_ahead_in = sum_ahead_ff;
      sum_front_in = sum_front_ff;
      sum_back_in  = sum_back_ff;
      avg_ir_in    = avg_ir_ff;
      avg_ahead_in = avg_ahead_ff;
      avg_front_in = avg_front_ff;
      avg_back_in  = avg_back_ff;
      diff_in      = diff_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               left_in      = (left_ff != '0) ? left_ff - HOLD_W'(1) : left_ff;
               right_in     = (right_ff != '0) ? right_ff - HOLD_W'(1) : right_ff;
               fin_pend_in  = fin_pend_ff | req_bus.finish_seen;
               res_in       = '0;
               avg_ir_in    = '0;
               avg_ahead_in = '0;
               avg_front_in = '0;
               avg_back_in  = '0;
               sum_ir_in    = '0;
               sum_ahead_in = '0;
               sum_front_in = '0;
               sum_back_in  = '0;
               cnt_in       = '0;
               state_in     = ST_PUSH;
               if (msg_ok) begin
                  if (slot_ff == LAST_IDX) begin
                     slot_in  = '0;
                     state_in = ST_SUM;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end
            end
         end
         ST_SUM: begin
            rd_vld_in = (cnt_ff < WIN_CNT);
            cnt_in    = cnt_ff + 1'b1;
            if (rd_vld_ff) begin
               sum_ir_in    = sum_ir_ff    + SUM_W'(win_rd_ff[4*BYTE_W-1:3*BYTE_W]);
               sum_ahead_in = sum_ahead_ff + SUM_W'(win_rd_ff[3*BYTE_W-1:2*BYTE_W]);
               sum_front_in = sum_front_ff + SUM_W'(win_rd_ff[2*BYTE_W-1:BYTE_W]);
               sum_back_in  = sum_back_ff  + SUM_W'(win_rd_ff[BYTE_W-1:0]);
            end
            if (cnt_ff == WIN_CNT) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            case (cnt_ff[1:0])
               2'd0:    avg_ir_in    = quot;
               2'd1:    avg_ahead_in = quot;
               2'd2:    avg_front_in = quot;
               default: avg_back_in  = quot;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               state_in = ST_CAL;
            end
         end
         ST_CAL: begin
            res_in.window_done = 1'b1;
            res_in.finish_flag = fin_pend_ff;
            fin_pend_in        = 1'b0;
            if (ref_ff == '0) begin
               ref_in = avg_front_ff;
            end
            if (awaiting_ff) begin
               wall_in     = avg_front_ff;
               awaiting_in = 1'b0;
               state_in    = ST_BOUND;
            end else begin
               state_in = ST_RING;
            end
         end
         ST_RING: begin
            cnt_in  = '0;
            diff_in = '0;
            if (ring_slot_ff == LAST_IDX) begin
               ring_slot_in = '0;
               state_in     = cfg_en ? ST_WALK : ST_BOUND;
            end else begin
               ring_slot_in = ring_slot_ff + 1'b1;
               state_in     = ST_BOUND;
            end
         end
         ST_WALK: begin
            rd_vld_in = (cnt_ff < WIN_CNT);
            cnt_in    = cnt_ff + 1'b1;
            if (rd_vld_ff) begin
               prev_in = ring_rd_ff;
               // first entry has no predecessor
               if (cnt_ff != CNT_W'(1) && term_ok) begin
                  diff_in = diff_ff + DIFF_W'(step);
               end
            end
            if (cnt_ff == WIN_CNT) begin
               cnt_in   = '0;
               state_in = ST_TREND;
            end
         end
         ST_TREND: begin
            res_in.trend_command = trend_cmd;
            left_in              = trend_l;
            right_in             = trend_r;
            state_in             = ST_BOUND;
         end
         ST_BOUND: begin
            if (cfg_en) begin
               res_in.boundary_command   = bound_cmd;
               res_in.blind_spot_command = blind_hit;
               left_in                   = final_l;
               right_in                  = final_r;
            end
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (push_fire) begin
         out_in            = res_ff;
         out_in.avg_ir     = avg_ir_ff;
         out_in.avg_ahead  = avg_ahead_ff;
         out_in.avg_front  = avg_front_ff;
         out_in.avg_back   = avg_back_ff;
         out_in.left_hold  = left_ff;
         out_in.right_hold = right_ff;
         rsp_valid_in      = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         slot_ff      <= '0;
         ring_slot_ff <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         ref_ff       <= '0;
         wall_ff      <= '0;
         awaiting_ff  <= 1'b1;
         fin_pend_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         ring_slot_ff <= ring_slot_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         ref_ff       <= ref_in;
         wall_ff      <= wall_in;
         awaiting_ff  <= awaiting_in;
         fin_pend_ff  <= fin_pend_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ir_ff    <= sum_ir_in;
      sum_ahead_ff <= sum_ahead_in;
      sum_front_ff <= sum_front_in;
      sum_back_ff  <= sum_back_in;
      avg_ir_ff    <= avg_ir_in;
      avg_ahead_ff <= avg_ahead_in;
      avg_front_ff <= avg_front_in;
      avg_back_ff  <= avg_back_in;
      diff_ff      <= diff_in;
      prev_ff      <= prev_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.window_done        = out_ff.window_done;
   assign rsp_bus.avg_ir             = out_ff.avg_ir;
   assign rsp_bus.avg_ahead          = out_ff.avg_ahead;
   assign rsp_bus.avg_front          = out_ff.avg_front;
   assign rsp_bus.avg_back           = out_ff.avg_back;
   assign rsp_bus.finish_flag        = out_ff.finish_flag;
   assign rsp_bus.trend_command      = out_ff.trend_command;
   assign rsp_bus.boundary_command   = out_ff.boundary_command;
   assign rsp_bus.blind_spot_command = out_ff.blind_spot_command;
   assign rsp_bus.left_hold          = out_ff.left_hold;
   assign rsp_bus.right_hold         = out_ff.right_hold;

   `WFSD_ASSERT(a_hold_limit, clock, reset, (left_ff <= HOLD_LONG) && (right_ff <= HOLD_LONG), "hold counter above limit")
   `WFSD_ASSERT_NEXT(a_window_start, clock, reset, req_acc && msg_ok && (slot_ff == LAST_IDX), state_ff == ST_SUM, "full window did not start the sum walk")
   `WFSD_ASSERT(a_walk_wrap, clock, reset, (state_ff == ST_WALK) |-> ((ring_slot_ff == '0) && cfg_en), "ring walk outside a wrap")
   `WFSD_ASSERT(a_cmd_window, clock, reset, (rsp_valid_ff && ((out_ff.trend_command != CMD_NONE) || (out_ff.boundary_command != CMD_NONE) || out_ff.blind_spot_command)) |-> out_ff.window_done, "command without a window")

endmodule

`default_nettype wire

// ----- bench/wall_follow_steering_decider_test.sv -----
// Self-checking bench for the wall-follow steering decider: directed table, then random traffic.
`default_nettype none

module wall_follow_steering_decider_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wfsd_pkg::*;

   localparam int WIN             = WINDOW_LEN_DEF;
   localparam int LONG_STALL      = 300;
   localparam int ITEMS_PER_PHASE = 285;
   localparam int SETTLE_CYCLES   = 30;

   // steering thresholds
   localparam int MIN_LEN    = 3;
   localparam int DIFF_BAND  = 13;
   localparam int RING_MAX   = 150;
   localparam int FRONT_MAX  = 175;
   localparam int IR_MIN     = 7;
   localparam int OFF_HARD   = -25;
   localparam int OFF_SOFT   = -15;
   localparam int IR_HARD    = 105;
   localparam int IR_SOFT    = 90;
   localparam int TREND_HARD = 7;
   localparam int TREND_SOFT = 3;
   localparam int BLIND_MAX  = 150;
   localparam int BLIND_GAP  = 10;
   localparam int REF_OFF    = 255;
   localparam int H_LONG     = 70;
   localparam int H_MID      = 50;
   localparam int H_SHORT    = 30;

   // {correction_enable, temp_correction_enable} per random phase
   localparam logic [1:0] PHASE_CFG [6] = '{2'b11, 2'b01, 2'b10, 2'b11, 2'b00, 2'b11};

   typedef struct packed {
      logic [7:0] msg_length;
      logic [7:0] ir_sample;
      logic [7:0] ahead_sample;
      logic [7:0] front_sample;
      logic [7:0] back_sample;
      logic       finish_seen;
   } sensor_msg_type;

   typedef struct packed {
      sensor_msg_type msg;
      logic           typed;
      res_type        want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   wfsd_req_if req_bus ();
   wfsd_rsp_if rsp_bus ();

   wall_follow_steering_decider DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   // steering model state
   int  ir_win [WIN];
   int  ahead_win [WIN];
   int  front_win [WIN];
   int  back_win [WIN];
   int  fill_count = 0;
   int  front_history [WIN];
   int  history_fill = 0;
   int  left_hold_now = 0;
   int  right_hold_now = 0;
   int  blind_ref = 0;
   int  wall_ref = 0;
   bit  first_window_pending = 1'b1;
   bit  finish_latched = 1'b0;
   bit  corr_en_now = 1'b0;
   bit  temp_en_now = 1'b0;

   // traffic shaping
   int  front_level = 60;
   int  ir_level = 60;
   int  front_drift = 0;
   int  fill_seen = 0;
   int  windows_sent = 0;
   int  burst_left = 0;
   bit  long_stall_request = 1'b0;

   // checking
   res_type      averages_due [$];
   stim_row_type directed_rows [$];
   logic         typed_pending;
   res_type      typed_want;
   int           fail_count = 0;
   int           result_count = 0;

   function automatic bit is_wellformed(sensor_msg_type m);
      return m.msg_length > MIN_LEN && m.front_sample != 0 && m.back_sample != 0;
   endfunction

   function automatic void set_holds(int left, int right);
      left_hold_now = left;
      right_hold_now = right;
   endfunction

   // advances the model by one message tick and returns its result
   function automatic res_type predict_tick(sensor_msg_type m);
      res_type r;
      int      si, sa, sf, sb, ai, af, drift, d, offset;
      bit      steer_en, veto;
      r = '0;
      if (left_hold_now > 0) left_hold_now--;
      if (right_hold_now > 0) right_hold_now--;
      if (m.finish_seen) finish_latched = 1'b1;
      if (is_wellformed(m)) begin
         ir_win[fill_count] = int'(m.ir_sample);
         ahead_win[fill_count] = int'(m.ahead_sample);
         front_win[fill_count] = int'(m.front_sample);
         back_win[fill_count] = int'(m.back_sample);
         fill_count++;
         if (fill_count == WIN) begin
            si = 0; sa = 0; sf = 0; sb = 0;
            for (int i = 0; i < WIN; i++) begin
               si += ir_win[i];
               sa += ahead_win[i];
               sf += front_win[i];
               sb += back_win[i];
            end
            ai = si / WIN;
            af = sf / WIN;
            r.window_done = 1'b1;
            r.avg_ir = BYTE_W'(ai);
            r.avg_ahead = BYTE_W'(sa / WIN);
            r.avg_front = BYTE_W'(af);
            r.avg_back = BYTE_W'(sb / WIN);
            if (blind_ref == 0) blind_ref = af;
            r.finish_flag = finish_latched;
            finish_latched = 1'b0;
            steer_en = corr_en_now && temp_en_now;
            veto = af > FRONT_MAX || ai < IR_MIN;
            if (first_window_pending) begin
               wall_ref = af;
               first_window_pending = 1'b0;
            end else begin
               front_history[history_fill] = af;
               history_fill++;
               if (history_fill == WIN) begin
                  if (steer_en && !veto) begin
                     drift = 0;
                     for (int i = 0; i + 1 < WIN; i++) begin
                        d = front_history[i + 1] - front_history[i];
                        if (d > -DIFF_BAND && d < DIFF_BAND && front_history[i] < RING_MAX &&
                            front_history[i + 1] < RING_MAX)
                           drift += d;
                     end
                     if (drift > TREND_HARD) begin
                        r.trend_command = CMD_RIGHT_STRONG;
                        set_holds(H_LONG, H_MID);
                     end else if (drift > TREND_SOFT) begin
                        r.trend_command = CMD_RIGHT_MILD;
                        set_holds(H_SHORT, H_MID);
                     end else if (drift < -TREND_HARD) begin
                        r.trend_command = CMD_LEFT_STRONG;
                        set_holds(H_MID, H_LONG);
                     end else if (drift < -TREND_SOFT) begin
                        r.trend_command = CMD_LEFT_MILD;
                        set_holds(H_MID, H_SHORT);
                     end
                  end
                  history_fill = 0;
               end
            end
            if (steer_en) begin
               offset = wall_ref - af;
               if (!veto) begin
                  if (offset < OFF_HARD && right_hold_now == 0) begin
                     r.boundary_command = CMD_RIGHT_STRONG;
                     set_holds(H_MID, H_LONG);
                  end else if (offset < OFF_SOFT && right_hold_now == 0) begin
                     r.boundary_command = CMD_RIGHT_MILD;
                     set_holds(H_SHORT, H_MID);
                  end else if (ai > IR_HARD && left_hold_now == 0) begin
                     r.boundary_command = CMD_LEFT_STRONG;
                     set_holds(H_LONG, H_MID);
                  end else if (ai > IR_SOFT && left_hold_now == 0) begin
                     r.boundary_command = CMD_LEFT_MILD;
                     set_holds(H_MID, H_SHORT);
                  end
               end
               // blind-spot rule ignores the veto
               if (blind_ref != 0 && blind_ref != REF_OFF && af < BLIND_MAX &&
                   af - BLIND_GAP < blind_ref && left_hold_now == 0) begin
                  r.blind_spot_command = 1'b1;
                  set_holds(H_LONG, H_MID);
               end
            end
            fill_count = 0;
         end
      end
      r.left_hold = HOLD_W'(left_hold_now);
      r.right_hold = HOLD_W'(right_hold_now);
      return r;
   endfunction

   // mostly well-formed messages whose front level drifts from window to window
   function automatic sensor_msg_type next_message();
      sensor_msg_type m;
      int             pick, level;
      pick = $urandom_range(0, 99);
      m.msg_length = BYTE_W'($urandom_range(4, 255));
      m.ir_sample = BYTE_W'($urandom);
      m.ahead_sample = BYTE_W'($urandom);
      m.front_sample = BYTE_W'($urandom_range(1, 255));
      m.back_sample = BYTE_W'($urandom_range(1, 255));
      m.finish_seen = ($urandom_range(0, 24) == 0);
      if (pick < 5) begin
         m.msg_length = BYTE_W'($urandom);
         m.front_sample = BYTE_W'($urandom);
         m.back_sample = BYTE_W'($urandom);
         m.finish_seen = 1'($urandom_range(0, 1));
      end else if (pick < 10) begin
         case ($urandom_range(0, 2))
            0: m.msg_length = BYTE_W'($urandom_range(0, MIN_LEN));
            1: m.front_sample = 8'd0;
            default: m.back_sample = 8'd0;
         endcase
      end else begin
         level = front_level + int'($urandom_range(0, 4)) - 2;
         m.front_sample = BYTE_W'(level < 1 ? 1 : (level > 255 ? 255 : level));
         level = ir_level + int'($urandom_range(0, 3));
         m.ir_sample = BYTE_W'(level > 255 ? 255 : level);
      end
      if (is_wellformed(m)) begin
         fill_seen++;
         if (fill_seen == WIN) begin
            fill_seen = 0;
            windows_sent++;
            if (windows_sent % WIN == 0) front_drift = int'($urandom_range(0, 8)) - 4;
            front_level += front_drift + int'($urandom_range(0, 2)) - 1;
            if (front_level > 190) begin
               front_level = 188;
               front_drift = -2;
            end else if (front_level < 15) begin
               front_level = 17;
               front_drift = 2;
            end
            if ($urandom_range(0, 2) == 0) ir_level = int'($urandom_range(0, 130));
         end
      end
      return m;
   endfunction

   function automatic string show(res_type r);
      return $sformatf("done=%0d ir=%0d ahead=%0d front=%0d back=%0d fin=%0d trend=%0d bound=%0d %s",
                       r.window_done, r.avg_ir, r.avg_ahead, r.avg_front, r.avg_back,
                       r.finish_flag, r.trend_command, r.boundary_command,
                       $sformatf("blind=%0d lhold=%0d rhold=%0d", r.blind_spot_command,
                                 r.left_hold, r.right_hold));
   endfunction

   function automatic bit results_match(res_type a, res_type b);
      return a.window_done === b.window_done && a.avg_ir === b.avg_ir &&
             a.avg_ahead === b.avg_ahead && a.avg_front === b.avg_front &&
             a.avg_back === b.avg_back && a.finish_flag === b.finish_flag &&
             a.trend_command === b.trend_command && a.boundary_command === b.boundary_command &&
             a.blind_spot_command === b.blind_spot_command && a.left_hold === b.left_hold &&
             a.right_hold === b.right_hold;
   endfunction

   function automatic void note_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("ERROR: %s", what);
   endfunction

   function automatic void add_row(input logic [7:0] len, ir, ahead, front, back,
                                   input logic fin, typed, input res_type want);
      stim_row_type row;
      row.msg = {len, ir, ahead, front, back, fin};
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   always @(posedge clock) begin : scoreboard
      res_type        got, want;
      sensor_msg_type seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.window_done = rsp_bus.window_done;
            got.avg_ir = rsp_bus.avg_ir;
            got.avg_ahead = rsp_bus.avg_ahead;
            got.avg_front = rsp_bus.avg_front;
            got.avg_back = rsp_bus.avg_back;
            got.finish_flag = rsp_bus.finish_flag;
            got.trend_command = cmd_type'(rsp_bus.trend_command);
            got.boundary_command = cmd_type'(rsp_bus.boundary_command);
            got.blind_spot_command = rsp_bus.blind_spot_command;
            got.left_hold = rsp_bus.left_hold;
            got.right_hold = rsp_bus.right_hold;
            result_count++;
            if (averages_due.size() == 0) begin
               note_failure($sformatf("result %0d with none expected: %s", result_count, show(got)));
            end else begin
               want = averages_due.pop_front();
               if (!results_match(want, got))
                  note_failure($sformatf("result %0d\n   expected %s\n   actual   %s",
                                         result_count, show(want), show(got)));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen = {req_bus.msg_length, req_bus.ir_sample, req_bus.ahead_sample,
                    req_bus.front_sample, req_bus.back_sample, req_bus.finish_seen};
            want = predict_tick(seen);
            averages_due.push_back(typed_pending ? typed_want : want);
         end
      end
   end

   // result side: changing stall patterns, plus one long hold-off on request
   initial begin : result_sink
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
            long_stall_request = 1'b0;
         end else begin
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            cyc++;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (cyc % 7) >= 3;
               default: rsp_bus.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   task automatic send_item(sensor_msg_type m, logic typed, res_type want);
      if (burst_left == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.msg_length <= m.msg_length;
      req_bus.ir_sample <= m.ir_sample;
      req_bus.ahead_sample <= m.ahead_sample;
      req_bus.front_sample <= m.front_sample;
      req_bus.back_sample <= m.back_sample;
      req_bus.finish_seen <= m.finish_seen;
      typed_pending <= typed;
      typed_want <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // write one enable register, then read it back
   task automatic write_enable_reg(csr_idx_type idx, logic value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_CORR_EN) corr_en_now = value;
      else temp_en_now = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DW'(value))
         note_failure($sformatf("register %s read back %0h, expected %0h",
                                idx.name(), csr_prdata, value));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (averages_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      res_type        quiet, first_avg;
      sensor_msg_type m;
      int             valid_count;
      bit             stall_done;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.msg_length = '0;
      req_bus.ir_sample = '0;
      req_bus.ahead_sample = '0;
      req_bus.front_sample = '0;
      req_bus.back_sample = '0;
      req_bus.finish_seen = 1'b0;
      typed_pending = 1'b0;
      typed_want = '0;
      stall_done = 1'b0;

      quiet = '0;
      first_avg = '0;
      first_avg.window_done = 1'b1;
      first_avg.avg_ir = 8'd100;
      first_avg.avg_ahead = 8'd255;
      first_avg.avg_front = 8'd60;
      first_avg.avg_back = 8'd1;
      first_avg.finish_flag = 1'b1;

      // rejected messages: nothing stored, finish still latched
      add_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, quiet);
      add_row(8'd3, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, quiet);
      add_row(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 1'b0, 1'b1, quiet);
      add_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, quiet);
      // first window calibrates wall offset and blind-spot reference to 60
      for (int i = 0; i < WIN; i++)
         add_row((i % 2) ? 8'd255 : 8'd4, 8'd100, 8'd255, 8'd60, 8'd1, 1'b0, 1'b1,
                 (i == WIN - 1) ? first_avg : quiet);
      // second window of extreme samples, one rejected message with finish inside
      for (int i = 0; i < WIN; i++) begin
         if (i == 3) add_row(8'd200, 8'd7, 8'd7, 8'd7, 8'd0, 1'b1, 1'b1, quiet);
         add_row((i % 2) ? 8'd4 : 8'd255, (i % 2) ? 8'd0 : 8'd255, (i % 2) ? 8'd255 : 8'd0,
                 (i % 2) ? 8'd1 : 8'd255, (i % 2) ? 8'd255 : 8'd1, 1'b0, 1'b0, quiet);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_enable_reg(CSR_CORR_EN, 1'b0);
      write_enable_reg(CSR_TEMP_EN, 1'b0);

      foreach (directed_rows[i])
         send_item(directed_rows[i].msg, directed_rows[i].typed, directed_rows[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         write_enable_reg(CSR_CORR_EN, PHASE_CFG[ph][1]);
         write_enable_reg(CSR_TEMP_EN, PHASE_CFG[ph][0]);
         valid_count = 0;
         while (valid_count < ITEMS_PER_PHASE) begin
            m = next_message();
            if (is_wellformed(m)) valid_count++;
            send_item(m, 1'b0, quiet);
            // hold the result side off while items keep coming
            if (ph == 1 && valid_count == 40 && !stall_done) begin
               stall_done = 1'b1;
               long_stall_request = 1'b1;
               burst_left = 60;
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
